// ===== design/bfp_pkg.sv =====
`timescale 1ns / 1ps

package bfp_pkg;

  localparam int MAX_BITS_DEF = 65536;
  localparam int HASH_W       = 32;
  localparam int BC_W         = 17;
  localparam int PC_W         = 5;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;

  localparam logic [BC_W-1:0] BC_RESET    = 17'd65536;
  localparam logic [PC_W-1:0] PC_RESET    = 5'd7;
  localparam logic [PC_W-1:0] PROBE_MIN   = 5'd1;
  localparam logic [PC_W-1:0] PROBE_LIMIT = 5'd30;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 8'd1;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/bfp_front.sv =====
`timescale 1ns / 1ps

module bfp_front #(
  parameter int MAX_BITS = bfp_pkg::MAX_BITS_DEF,
  parameter int MW       = $clog2(MAX_BITS + 1),
  parameter int PW       = $clog2(MAX_BITS),
  parameter int JW       = 1 + 2 * PW
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      kind,
  input  logic [bfp_pkg::HASH_W-1:0] hash_a,
  input  logic [bfp_pkg::HASH_W-1:0] hash_b,
  input  logic [MW-1:0]             m,
  input  logic                      clear_busy,
  input  bfp_pkg::q_status_t        qst,
  output logic                      busy,
  output logic                      push,
  output logic [JW-1:0]             job
);
  import bfp_pkg::*;

  localparam int RW = MW + 1;
  localparam int CW = $clog2(HASH_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(HASH_W - 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RUN  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]        state;
  logic [CW-1:0]     cnt;
  logic              kind_r;
  logic [HASH_W-1:0] a_sh;
  logic [HASH_W-1:0] b_sh;
  logic [RW-1:0]     ra;
  logic [RW-1:0]     rb;
  logic [RW-1:0]     ra_sh;
  logic [RW-1:0]     rb_sh;
  logic [RW-1:0]     ra_next;
  logic [RW-1:0]     rb_next;
  logic [RW-1:0]     m_ext;
  logic              accept;

  assign busy   = (state != F_IDLE) || clear_busy;
  assign accept = start && !busy;
  assign push   = (state == F_PUSH) && !qst.full;
  assign job    = {kind_r, ra[PW-1:0], rb[PW-1:0]};

  // one restoring remainder step per cycle on both hashes
  always_comb begin
    m_ext   = RW'(m);
    ra_sh   = {ra[RW-2:0], a_sh[HASH_W-1]};
    rb_sh   = {rb[RW-2:0], b_sh[HASH_W-1]};
    ra_next = (ra_sh >= m_ext) ? (ra_sh - m_ext) : ra_sh;
    rb_next = (rb_sh >= m_ext) ? (rb_sh - m_ext) : rb_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            kind_r <= kind;
            a_sh   <= hash_a;
            b_sh   <= hash_b | HASH_W'(1);
            ra     <= '0;
            rb     <= '0;
            cnt    <= '0;
            state  <= F_RUN;
          end
        end
        F_RUN: begin
          a_sh <= a_sh << 1;
          b_sh <= b_sh << 1;
          ra   <= ra_next;
          rb   <= rb_next;
          cnt  <= cnt + CW'(1);
          if (cnt == CNT_LAST) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!qst.full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== design/bfp_queue.sv =====
`timescale 1ns / 1ps

module bfp_queue #(
  parameter int JW = 33
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [JW-1:0]      din,
  input  logic               pop,
  output logic [JW-1:0]      dout,
  output bfp_pkg::q_status_t qst
);
  import bfp_pkg::*;

  logic [JW-1:0] slots [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign dout      = slots[rptr];
  assign qst.full  = (count == 2'd2);
  assign qst.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/bfp_back.sv =====
`timescale 1ns / 1ps

module bfp_back #(
  parameter int MAX_BITS = bfp_pkg::MAX_BITS_DEF,
  parameter int MW       = $clog2(MAX_BITS + 1),
  parameter int PW       = $clog2(MAX_BITS),
  parameter int JW       = 1 + 2 * PW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [MW-1:0]          m,
  input  logic [bfp_pkg::PC_W-1:0] probes,
  input  bfp_pkg::q_status_t     qst,
  input  logic [JW-1:0]          job,
  output logic                   pop,
  output logic                   clearing,
  output logic                   done,
  output logic                   maybe_present
);
  import bfp_pkg::*;

  localparam int DEPTH = (MAX_BITS + 7) / 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

  logic [7:0]      mem [DEPTH];
  logic [7:0]      rdata;
  logic [AW-1:0]   clr_addr;

  logic            active;
  logic            kind_r;
  logic [PW-1:0]   pos_r;
  logic [PW-1:0]   step_r;
  logic [PC_W-1:0] left;

  logic            s1_valid;
  logic [AW-1:0]   s1_addr;
  logic [2:0]      s1_bit;
  logic            s1_last;

  logic            fwd_valid;
  logic [AW-1:0]   fwd_addr;
  logic [7:0]      fwd_data;

  logic [PW-1:0]   byte_pos;
  logic [AW-1:0]   rd_addr;
  logic [PW:0]     pos_sum;
  logic [PW:0]     m_ext;
  logic [PW-1:0]   pos_next;
  logic [7:0]      cur;
  logic [7:0]      wdata;
  logic            bit_set;
  logic            miss;
  logic            finish;
  logic            issue;
  logic            we_probe;

  assign pop = !active && !qst.empty && !clearing;

  always_comb begin
    byte_pos = pos_r >> 3;
    rd_addr  = byte_pos[AW-1:0];
    m_ext    = (PW + 1)'(m);
    pos_sum  = {1'b0, pos_r} + {1'b0, step_r};
    pos_next = (pos_sum >= m_ext) ? PW'(pos_sum - m_ext) : pos_sum[PW-1:0];
    // the previous probe may have just written the same byte
    cur      = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rdata;
    bit_set  = cur[s1_bit];
    wdata    = cur | (8'd1 << s1_bit);
    miss     = s1_valid && (kind_r == KIND_QUERY) && !bit_set;
    finish   = s1_valid && (miss || s1_last);
    we_probe = s1_valid && (kind_r == KIND_ADD);
    issue    = active && (left != '0) && !finish;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'd0;
    end else if (we_probe) begin
      mem[s1_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s1_addr;
    fwd_data <= wdata;
    if (pop) begin
      kind_r <= job[JW-1];
      pos_r  <= job[2*PW-1:PW];
      step_r <= job[PW-1:0];
    end else if (issue) begin
      pos_r <= pos_next;
    end
    if (issue) begin
      s1_addr <= rd_addr;
      s1_bit  <= pos_r[2:0];
      s1_last <= (left == PC_W'(1));
    end
    if (finish) begin
      maybe_present <= !miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      active    <= 1'b0;
      left      <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      fwd_valid <= we_probe;
      done      <= finish;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == ADDR_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        active <= 1'b1;
        left   <= probes;
      end else if (issue) begin
        left <= left - PC_W'(1);
      end
      s1_valid <= issue;
      if (finish) begin
        active <= 1'b0;
      end
    end
  end

endmodule

// ===== design/bloom_filter_probe_top.sv =====
`timescale 1ns / 1ps

// bloom filter bit store with double hashing
// command channel: drive kind/hash_a/hash_b with start; the transaction is taken
// when start is high and busy is low. kind 0 adds the key, kind 1 queries it.
// result: done pulses for one cycle with maybe_present (always 1 for an add).
// the receiver cannot stall; every command yields exactly one result, in order.
// front end reduces hash_a and hash_b modulo the bit count with a one-bit-per-cycle
// remainder unit, and takes no new command until its job is pushed into the queue.
// back end walks the probes from a two-entry job queue, one byte read-modify-write
// per cycle through one read and one write port of the store, and pops a new job only
// after the last one finishes (a query stops at the first clear bit).
// config port: cfg_index 0 = bit count, 1 = probe count; other indexes are
// dropped. write it only while no command is in flight; cfg_ready is always high.
// reset restores bit count 65536, probe count 7 and clears the store one byte a
// cycle, all (MAX_BITS + 7) / 8 bytes (8192 by default), with busy held high.

module bloom_filter_probe_top #(
  parameter int MAX_BITS = bfp_pkg::MAX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [bfp_pkg::HASH_W-1:0]    hash_a,
  input  logic [bfp_pkg::HASH_W-1:0]    hash_b,
  output logic                          done,
  output logic                          maybe_present,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bfp_pkg::*;

  localparam int MW = $clog2(MAX_BITS + 1);
  localparam int PW = $clog2(MAX_BITS);
  localparam int JW = 1 + 2 * PW;

  logic [BC_W-1:0] filter_size;
  logic [PC_W-1:0] probe_count;
  logic [31:0]     bc_wide;
  logic [31:0]     m_wide;
  logic [MW-1:0]   m;
  logic [PC_W-1:0] probes;

  logic            push;
  logic            pop;
  logic [JW-1:0]   job_in;
  logic [JW-1:0]   job_out;
  q_status_t       qst;
  logic            clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_size <= BC_RESET;
      probe_count <= PC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIT_COUNT:   filter_size <= cfg_data[BC_W-1:0];
        REG_PROBE_COUNT: probe_count <= cfg_data[PC_W-1:0];
        default: ;
      endcase
    end
  end

  // zero or oversized bit counts fall back to the full store; probes clamp to 1..30
  always_comb begin
    bc_wide = 32'(filter_size);
    if ((bc_wide == 32'd0) || (bc_wide > 32'(MAX_BITS))) begin
      m_wide = 32'(MAX_BITS);
    end else begin
      m_wide = bc_wide;
    end
    m = m_wide[MW-1:0];
    if (probe_count < PROBE_MIN) begin
      probes = PROBE_MIN;
    end else if (probe_count > PROBE_LIMIT) begin
      probes = PROBE_LIMIT;
    end else begin
      probes = probe_count;
    end
  end

  bfp_front #(
    .MAX_BITS (MAX_BITS),
    .MW       (MW),
    .PW       (PW),
    .JW       (JW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .hash_a     (hash_a),
    .hash_b     (hash_b),
    .m          (m),
    .clear_busy (clearing),
    .qst        (qst),
    .busy       (busy),
    .push       (push),
    .job        (job_in)
  );

  bfp_queue #(
    .JW (JW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (job_in),
    .pop  (pop),
    .dout (job_out),
    .qst  (qst)
  );

  bfp_back #(
    .MAX_BITS (MAX_BITS),
    .MW       (MW),
    .PW       (PW),
    .JW       (JW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .m             (m),
    .probes        (probes),
    .qst           (qst),
    .job           (job_out),
    .pop           (pop),
    .clearing      (clearing),
    .done          (done),
    .maybe_present (maybe_present)
  );

endmodule

// ===== design/bfp_checker.sv =====
`timescale 1ns / 1ps

module bfp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           kind,
  input logic [bfp_pkg::HASH_W-1:0]     hash_a,
  input logic [bfp_pkg::HASH_W-1:0]     hash_b,
  input logic                           done,
  input logic                           maybe_present,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [bfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [bfp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bfp_pkg::*;

  // store clearing starts right after reset, so no command can be taken
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but front end not busy");

  // done strobes never come back to back
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held two cycles");

endmodule

bind bloom_filter_probe_top bfp_checker u_bfp_checker (.*);
